/* sv/adsr_pkg.sv */
// ADSR envelope generator: shared widths, codes, stage and sequencer types.
// No dependencies; compiled first.
`default_nettype none

package adsr_pkg;

    // Field and register widths
    localparam int LVL_W      = 17;   // Q16 level, 65536 = 1.0
    localparam int DUR_W      = 24;   // stage durations in samples
    localparam int PHASE_W    = 16;   // Q16 fraction of stage elapsed
    localparam int BLK_W      = 16;   // samples per block
    localparam int MIN_W      = 8;    // minimum stage length
    localparam int REQ_W      = 2;
    localparam int STAGE_W    = 3;
    localparam int DT_W       = DUR_W + 1;  // carried time, below 2^24 + 2^16
    localparam int SUM_W      = DUR_W + 2;  // elapsed + carried time
    localparam int PROD_W     = 2 * LVL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DUR_W;

    localparam int MAX_TRANSITIONS = 8;
    localparam int STEP_CNT_W      = $clog2(MAX_TRANSITIONS);
    localparam int DIV_CNT_W       = $clog2(PHASE_W);

    localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(65536);

    // Request codes; the unused code behaves as an advance
    localparam logic [REQ_W-1:0] REQ_ADVANCE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_CUR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NOTE_ZERO = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd6;

    // Register reset values
    localparam logic [DUR_W-1:0] RST_ATTACK  = DUR_W'(480);
    localparam logic [DUR_W-1:0] RST_DECAY   = DUR_W'(9600);
    localparam logic [DUR_W-1:0] RST_RELEASE = DUR_W'(14400);
    localparam logic [LVL_W-1:0] RST_SUSTAIN = LVL_W'(45875);
    localparam logic [LVL_W-1:0] RST_DEPTH   = LVL_W'(65536);
    localparam logic [MIN_W-1:0] RST_MIN     = MIN_W'(4);

    typedef enum logic [STAGE_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_STEP,
        SQ_DIV,
        SQ_LERP,
        SQ_LERP_WB,
        SQ_MOD,
        SQ_MOD_WB
    } t_seq;

    function automatic logic [LVL_W-1:0] clamp_fs(input logic [LVL_W-1:0] v);
        return (v > FULL_SCALE) ? FULL_SCALE : v;
    endfunction

endpackage

`default_nettype wire

/* sv/adsr_in_if.sv */
// Request channel of the ADSR envelope generator: valid/ready plus payload.
// Depends on adsr_pkg.
`default_nettype none

interface adsr_in_if;
    logic                            valid;
    logic                            ready;
    logic [adsr_pkg::REQ_W-1:0]      req_type;
    logic                            gate;
    logic [adsr_pkg::BLK_W-1:0]      block_samples;

    modport source (output valid, output req_type, output gate, output block_samples,
                    input ready);
    modport sink   (input valid, input req_type, input gate, input block_samples,
                    output ready);
endinterface

`default_nettype wire

/* sv/adsr_out_if.sv */
// Result channel of the ADSR envelope generator: valid/ready plus payload.
// Depends on adsr_pkg.
`default_nettype none

interface adsr_out_if;
    logic                            valid;
    logic                            ready;
    logic [adsr_pkg::LVL_W-1:0]      env_level;
    logic [adsr_pkg::LVL_W-1:0]      mod_level;
    logic [adsr_pkg::STAGE_W-1:0]    stage_code;
    logic [adsr_pkg::PHASE_W-1:0]    stage_progress;

    modport source (output valid, output env_level, output mod_level, output stage_code,
                    output stage_progress, input ready);
    modport sink   (input valid, input env_level, input mod_level, input stage_code,
                    input stage_progress, output ready);
endinterface

`default_nettype wire

/* sv/adsr_div.sv */
// Restoring divider for stage phase: (elapsed << 16) / duration, elapsed < duration.
// One quotient bit per cycle. Depends on adsr_pkg.
`default_nettype none

module adsr_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [adsr_pkg::DUR_W-1:0]    i_dividend,
    input  wire logic [adsr_pkg::DUR_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [adsr_pkg::PHASE_W-1:0]       o_quotient
);

    logic [adsr_pkg::DUR_W-1:0]     r_rem;
    logic [adsr_pkg::DUR_W-1:0]     r_den;
    logic [adsr_pkg::PHASE_W-1:0]   r_quo;
    logic [adsr_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [adsr_pkg::DUR_W:0]       w_shift;
    logic                           w_ge;
    logic [adsr_pkg::DUR_W:0]       w_diff;

    // remainder stays below the divisor, so one compare/subtract per bit
    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_ge    = w_shift >= {1'b0, r_den};
        w_diff  = w_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == adsr_pkg::DIV_CNT_W'(adsr_pkg::PHASE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_den <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[adsr_pkg::DUR_W-1:0] : w_shift[adsr_pkg::DUR_W-1:0];
            r_quo <= {r_quo[adsr_pkg::PHASE_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* sv/adsr_mul.sv */
// Shared 17x17 multiplier with registered product; used for the segment
// interpolation and for the depth scaling. Depends on adsr_pkg.
`default_nettype none

module adsr_mul (
    input  wire logic                          i_clk,
    input  wire logic [adsr_pkg::LVL_W-1:0]    i_a,
    input  wire logic [adsr_pkg::LVL_W-1:0]    i_b,
    output logic [adsr_pkg::PROD_W-1:0]        o_prod
);

    logic [adsr_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= adsr_pkg::PROD_W'(i_a) * adsr_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* sv/adsr_envelope_generator.sv */
// ADSR envelope generator top level: config registers, stage sequencer,
// envelope state. Depends on adsr_pkg, adsr_in_if, adsr_out_if, adsr_div, adsr_mul.
`default_nettype none

// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   req_type[1:0], gate, block_samples[15:0]
// o_res     out  valid/ready   env_level[16:0], mod_level[16:0], stage_code[2:0],
//                              stage_progress[15:0]
// i_cfg_*   in   write enable  i_cfg_idx[2:0], i_cfg_data[23:0]
//
// One transaction in gives one transaction out. A note-on goes from acceptance
// through the depth scaling and its write-back to a loaded result register. An
// advance takes one step of the stage machine per cycle (1 to 8 steps), and when
// it stops inside a timed stage the bit-serial phase divider follows and dominates.
// i_req.ready is high only while the sequencer is idle; a finished result
// waits in the output register, so the next request is taken while it stalls.
// A new result waits in the sequencer until the output register frees up.
// Synchronous reset clears the envelope and restores register defaults.

module adsr_envelope_generator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [adsr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    adsr_in_if.sink                                 i_req,
    adsr_out_if.source                              o_res
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [adsr_pkg::DUR_W-1:0]  r_atk, r_dec, r_rel;
    logic [adsr_pkg::LVL_W-1:0]  r_sus, r_depth;
    logic                        r_mode;   // 0 free running, 1 gated
    logic [adsr_pkg::MIN_W-1:0]  r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atk   <= adsr_pkg::RST_ATTACK;
            r_dec   <= adsr_pkg::RST_DECAY;
            r_rel   <= adsr_pkg::RST_RELEASE;
            r_sus   <= adsr_pkg::RST_SUSTAIN;
            r_depth <= adsr_pkg::RST_DEPTH;
            r_mode  <= 1'b0;
            r_min   <= adsr_pkg::RST_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                adsr_pkg::CFG_ATTACK:  r_atk   <= i_cfg_data;
                adsr_pkg::CFG_DECAY:   r_dec   <= i_cfg_data;
                adsr_pkg::CFG_RELEASE: r_rel   <= i_cfg_data;
                adsr_pkg::CFG_SUSTAIN: r_sus   <= i_cfg_data[adsr_pkg::LVL_W-1:0];
                adsr_pkg::CFG_DEPTH:   r_depth <= i_cfg_data[adsr_pkg::LVL_W-1:0];
                adsr_pkg::CFG_MODE:    r_mode  <= i_cfg_data[0];
                adsr_pkg::CFG_MIN:     r_min   <= i_cfg_data[adsr_pkg::MIN_W-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Envelope state and sequencer registers
    // ---------------------------------------------------------------
    adsr_pkg::t_seq    r_sq, n_sq;
    adsr_pkg::t_stage  r_stage, n_stage;
    // Elapsed time is only kept while below the stage duration, so it never
    // gets near saturation; 24 bits hold it.
    logic [adsr_pkg::DUR_W-1:0]       r_elapsed, n_elapsed;
    logic [adsr_pkg::LVL_W-1:0]       r_seg_start, n_seg_start;
    logic [adsr_pkg::LVL_W-1:0]       r_seg_end, n_seg_end;
    logic [adsr_pkg::LVL_W-1:0]       r_level, n_level;
    logic [adsr_pkg::PHASE_W-1:0]     r_phase, n_phase;
    logic                             r_prev_gate, n_prev_gate;
    logic [adsr_pkg::DT_W-1:0]        r_dt, n_dt;          // time still to spend
    logic                             r_free, n_free;
    logic                             r_gate_open, n_gate_open;
    logic [adsr_pkg::STEP_CNT_W-1:0]  r_nstep, n_nstep;

    // Output register
    logic                             r_out_valid;
    logic [adsr_pkg::LVL_W-1:0]       r_out_env, r_out_mod;
    adsr_pkg::t_stage                 r_out_stage;
    logic [adsr_pkg::PHASE_W-1:0]     r_out_prog;

    logic w_accept, w_out_free, w_note_on;
    logic w_gate_open;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_note_on  = (i_req.req_type == adsr_pkg::REQ_NOTE_CUR)
                     || (i_req.req_type == adsr_pkg::REQ_NOTE_ZERO);
    assign w_gate_open = !r_mode || i_req.gate;   // free mode holds the gate open

    // ---------------------------------------------------------------
    // Stage step signals
    // ---------------------------------------------------------------
    logic                           w_timed;
    logic [adsr_pkg::DUR_W-1:0]     w_dur;
    logic [adsr_pkg::LVL_W-1:0]     w_end;
    adsr_pkg::t_stage               w_next;
    logic [adsr_pkg::SUM_W-1:0]     w_sum;
    logic [adsr_pkg::SUM_W-1:0]     w_over;
    logic                           w_skip;
    logic                           w_ended;
    logic                           w_goes_on;
    logic [adsr_pkg::DT_W-1:0]      w_left;
    logic                           w_last;
    logic [adsr_pkg::LVL_W-1:0]     w_sus;

    // ---------------------------------------------------------------
    // Shared units
    // ---------------------------------------------------------------
    logic                           w_div_start, w_div_done;
    logic [adsr_pkg::PHASE_W-1:0]   w_quotient;
    logic [adsr_pkg::LVL_W-1:0]     w_mul_a, w_mul_b;
    logic [adsr_pkg::PROD_W-1:0]    w_prod;

    adsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_elapsed),
        .i_divisor  (w_dur),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    adsr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // ---------------------------------------------------------------
    // One transition step of the stage machine, evaluated on the current stage.
    // Every stage has an end level and a successor; sustain and idle are
    // untimed and go on only in free mode.
    // ---------------------------------------------------------------
    always_comb begin
        w_sus = adsr_pkg::clamp_fs(r_sus);
        unique case (r_stage)
            adsr_pkg::ST_ATTACK: begin
                w_timed = 1'b1;
                w_dur   = r_atk;
                w_end   = adsr_pkg::FULL_SCALE;
                w_next  = adsr_pkg::ST_DECAY;
            end
            adsr_pkg::ST_DECAY: begin
                w_timed = 1'b1;
                w_dur   = r_dec;
                w_end   = w_sus;
                w_next  = adsr_pkg::ST_SUSTAIN;
            end
            adsr_pkg::ST_RELEASE: begin
                w_timed = 1'b1;
                w_dur   = r_rel;
                w_end   = '0;
                w_next  = adsr_pkg::ST_IDLE;
            end
            adsr_pkg::ST_SUSTAIN: begin
                w_timed = 1'b0;
                w_dur   = '0;
                w_end   = w_sus;
                w_next  = adsr_pkg::ST_RELEASE;
            end
            default: begin  // idle
                w_timed = 1'b0;
                w_dur   = '0;
                w_end   = '0;
                w_next  = adsr_pkg::ST_ATTACK;
            end
        endcase

        w_sum   = adsr_pkg::SUM_W'(r_elapsed) + adsr_pkg::SUM_W'(r_dt);
        w_over  = w_sum - adsr_pkg::SUM_W'(w_dur);
        w_skip  = w_dur <= adsr_pkg::DUR_W'(r_min);
        w_ended = w_skip || (w_sum >= adsr_pkg::SUM_W'(w_dur));
        // a skipped stage costs no time
        w_left  = (w_timed && !w_skip) ? w_over[adsr_pkg::DT_W-1:0] : r_dt;

        if (w_timed)
            w_goes_on = w_ended;
        else if (r_stage == adsr_pkg::ST_SUSTAIN)
            w_goes_on = r_free;
        else
            w_goes_on = r_free && r_gate_open;

        w_last = r_nstep == adsr_pkg::STEP_CNT_W'(adsr_pkg::MAX_TRANSITIONS - 1);
    end

    // ---------------------------------------------------------------
    // Sequencer next state
    // ---------------------------------------------------------------
    always_comb begin
        n_sq = r_sq;
        unique case (r_sq)
            adsr_pkg::SQ_IDLE: begin
                if (w_accept)
                    n_sq = w_note_on ? adsr_pkg::SQ_MOD : adsr_pkg::SQ_STEP;
            end
            adsr_pkg::SQ_STEP: begin
                if (w_goes_on)
                    n_sq = w_last ? adsr_pkg::SQ_MOD : adsr_pkg::SQ_STEP;
                else
                    n_sq = w_timed ? adsr_pkg::SQ_DIV : adsr_pkg::SQ_MOD;
            end
            adsr_pkg::SQ_DIV: begin
                if (w_div_done)
                    n_sq = adsr_pkg::SQ_LERP;
            end
            adsr_pkg::SQ_LERP:    n_sq = adsr_pkg::SQ_LERP_WB;
            adsr_pkg::SQ_LERP_WB: n_sq = adsr_pkg::SQ_MOD;
            adsr_pkg::SQ_MOD:     n_sq = adsr_pkg::SQ_MOD_WB;
            adsr_pkg::SQ_MOD_WB: begin
                if (w_out_free)
                    n_sq = adsr_pkg::SQ_IDLE;
            end
            default: n_sq = adsr_pkg::SQ_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer outputs: envelope datapath and shared-unit operands
    // ---------------------------------------------------------------
    logic [adsr_pkg::LVL_W-1:0] w_span;
    logic                       w_rising;
    logic [adsr_pkg::LVL_W-1:0] w_note_start;

    always_comb begin
        n_stage     = r_stage;
        n_elapsed   = r_elapsed;
        n_seg_start = r_seg_start;
        n_seg_end   = r_seg_end;
        n_level     = r_level;
        n_phase     = r_phase;
        n_prev_gate = r_prev_gate;
        n_dt        = r_dt;
        n_free      = r_free;
        n_gate_open = r_gate_open;
        n_nstep     = r_nstep;
        w_div_start = 1'b0;

        w_rising     = r_seg_end >= r_seg_start;
        w_span       = w_rising ? (r_seg_end - r_seg_start) : (r_seg_start - r_seg_end);
        w_note_start = (i_req.req_type == adsr_pkg::REQ_NOTE_ZERO) ? '0 : r_level;

        // multiplier: span x phase while interpolating, level x depth otherwise
        if (r_sq == adsr_pkg::SQ_LERP) begin
            w_mul_a = w_span;
            w_mul_b = adsr_pkg::LVL_W'(r_phase);
        end else begin
            w_mul_a = r_level;
            w_mul_b = adsr_pkg::clamp_fs(r_depth);
        end

        unique case (r_sq)
            adsr_pkg::SQ_IDLE: begin
                if (w_accept) begin
                    n_nstep = '0;
                    if (w_note_on) begin
                        // restart attack at once, no time passes
                        n_stage     = adsr_pkg::ST_ATTACK;
                        n_elapsed   = '0;
                        n_phase     = '0;
                        n_seg_start = w_note_start;
                        n_level     = w_note_start;
                        n_prev_gate = 1'b1;
                    end else begin
                        n_free      = !r_mode;
                        n_gate_open = w_gate_open;
                        n_dt        = adsr_pkg::DT_W'(i_req.block_samples);
                        n_prev_gate = w_gate_open;
                        priority if (w_gate_open && !r_prev_gate) begin
                            n_stage     = adsr_pkg::ST_ATTACK;
                            n_elapsed   = '0;
                            n_phase     = '0;
                            n_seg_start = r_level;
                        end else if (!w_gate_open && r_prev_gate &&
                                     r_stage != adsr_pkg::ST_IDLE) begin
                            n_stage     = adsr_pkg::ST_RELEASE;
                            n_elapsed   = '0;
                            n_phase     = '0;
                            n_seg_start = r_level;
                        end else begin
                        end
                    end
                end
            end
            adsr_pkg::SQ_STEP: begin
                if (w_goes_on) begin
                    // stage over: land on its end level and enter the next one
                    n_level     = w_end;
                    n_stage     = w_next;
                    n_elapsed   = '0;
                    n_phase     = '0;
                    n_seg_start = w_end;
                    n_dt        = w_left;
                    n_nstep     = r_nstep + 1'b1;
                end else if (w_timed) begin
                    // stays inside a timed stage: compute the phase
                    n_elapsed   = w_sum[adsr_pkg::DUR_W-1:0];
                    n_seg_end   = w_end;
                    w_div_start = 1'b1;
                end else begin
                    // held in sustain or idle
                    n_level = w_end;
                    n_phase = '0;
                end
            end
            adsr_pkg::SQ_DIV: begin
                if (w_div_done)
                    n_phase = w_quotient;
            end
            adsr_pkg::SQ_LERP_WB: begin
                // move from the segment start toward its end, truncating
                n_level = w_rising
                        ? (r_seg_start + w_prod[adsr_pkg::LVL_W+15:16])
                        : (r_seg_start - w_prod[adsr_pkg::LVL_W+15:16]);
            end
            adsr_pkg::SQ_LERP, adsr_pkg::SQ_MOD, adsr_pkg::SQ_MOD_WB: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq        <= adsr_pkg::SQ_IDLE;
            r_stage     <= adsr_pkg::ST_IDLE;
            r_elapsed   <= '0;
            r_seg_start <= '0;
            r_level     <= '0;
            r_phase     <= '0;
            r_prev_gate <= 1'b0;
            r_nstep     <= '0;
        end else begin
            r_sq        <= n_sq;
            r_stage     <= n_stage;
            r_elapsed   <= n_elapsed;
            r_seg_start <= n_seg_start;
            r_level     <= n_level;
            r_phase     <= n_phase;
            r_prev_gate <= n_prev_gate;
            r_nstep     <= n_nstep;
        end
    end

    // working values of the current transaction
    always_ff @(posedge i_clk) begin
        r_seg_end   <= n_seg_end;
        r_dt        <= n_dt;
        r_free      <= n_free;
        r_gate_open <= n_gate_open;
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic w_load;
    assign w_load = (r_sq == adsr_pkg::SQ_MOD_WB) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_env   <= r_level;
            r_out_mod   <= w_prod[adsr_pkg::LVL_W+15:16];
            r_out_stage <= r_stage;
            r_out_prog  <= r_phase;
        end
    end

    assign i_req.ready          = (r_sq == adsr_pkg::SQ_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.env_level      = r_out_env;
    assign o_res.mod_level      = r_out_mod;
    assign o_res.stage_code     = r_out_stage;
    assign o_res.stage_progress = r_out_prog;

endmodule

`default_nettype wire

/* sv/adsr_chk.sv */
// Port-level checker for the ADSR envelope generator, bound to the top level.
// Depends on adsr_pkg.
`default_nettype none

module adsr_chk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [adsr_pkg::LVL_W-1:0]    i_env_level,
    input  wire logic [adsr_pkg::LVL_W-1:0]    i_mod_level,
    input  wire logic [adsr_pkg::STAGE_W-1:0]  i_stage_code,
    input  wire logic [adsr_pkg::PHASE_W-1:0]  i_stage_progress
);

    // one transaction at a time: the sequencer is busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while sequencer busy");

    // depth is at most full scale, so the scaled level never exceeds the level
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_env_level <= adsr_pkg::FULL_SCALE) && (i_mod_level <= i_env_level))
        else $error("envelope or scaled level out of range");

    // untimed stages report no progress
    a_untimed_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_stage_code == adsr_pkg::ST_IDLE
                      || i_stage_code == adsr_pkg::ST_SUSTAIN)) |-> (i_stage_progress == '0))
        else $error("progress reported in idle or sustain");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_env_level)
            && $stable(i_mod_level) && $stable(i_stage_code) && $stable(i_stage_progress))
        else $error("result changed while stalled");

endmodule

bind adsr_envelope_generator adsr_chk u_adsr_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_env_level      (o_res.env_level),
    .i_mod_level      (o_res.mod_level),
    .i_stage_code     (o_res.stage_code),
    .i_stage_progress (o_res.stage_progress)
);

`default_nettype wire
